### design/sha1md_pkg.sv
// Shared types and constants of the SHA-1 message digest block.
`timescale 1ns / 1ps
`default_nettype none
package sha1md_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_word_t;

  typedef struct packed {
    logic [31:0] data;
    logic        last;
  } qent_t;

  typedef logic [4:0][31:0] chain_t;

  localparam chain_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                           32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam logic [QAW:0] QFULL = (QAW + 1)'(QDEPTH);

  localparam logic [3:0] LEN_SLOT    = 4'd14;
  localparam logic [4:0] STAGE_FULL  = 5'd16;
  localparam logic [2:0] FULL_BYTES  = 3'd4;
  localparam logic [2:0] LAST_INDEX  = 3'd4;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [6:0] ROUND_K1    = 7'd20;
  localparam logic [6:0] ROUND_K2    = 7'd40;
  localparam logic [6:0] ROUND_K3    = 7'd60;

endpackage
`default_nettype wire

### design/sha1md_queue.sv
// Short word queue between the padding front end and the compression core.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sha1md_pkg::qent_t push_ent,
  output logic              full,
  output logic              pop_valid,
  output sha1md_pkg::qent_t pop_ent,
  input  logic              pop
);
  import sha1md_pkg::*;

  qent_t            mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == QFULL);
  assign pop_valid = (count != '0);
  assign pop_ent   = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

endmodule
`default_nettype wire

### design/sha1md_front.sv
// Front end: takes message words, counts the length and generates the padding.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  sha1md_pkg::msg_word_t msg_word,
  output logic                  push,
  output sha1md_pkg::qent_t     push_ent,
  input  logic                  full
);
  import sha1md_pkg::*;

  typedef enum logic [3:0] {
    F_PASS  = 4'b0001,
    F_PAD80 = 4'b0010,
    F_PAD   = 4'b0100,
    F_LENLO = 4'b1000
  } fstate_t;

  fstate_t     state;
  fstate_t     state_next;
  logic [63:0] bit_length;
  logic [63:0] bit_length_next;
  logic [3:0]  fill;
  logic        take;
  logic [2:0]  nbytes;

  function automatic logic [31:0] pad_word(input logic [31:0] data, input logic [2:0] n);
    logic [31:0] w;
    case (n)
      3'd0:    w = PAD_WORD;
      3'd1:    w = {data[31:24], PAD_BYTE, 16'h0000};
      3'd2:    w = {data[31:16], PAD_BYTE, 8'h00};
      3'd3:    w = {data[31:8], PAD_BYTE};
      default: w = data;
    endcase
    return w;
  endfunction

  assign msg_stall = (state != F_PASS) || full;
  assign take      = msg_valid && !msg_stall;
  assign nbytes    = (msg_word.valid_bytes > FULL_BYTES) ? FULL_BYTES : msg_word.valid_bytes;

  always_comb begin
    push            = 1'b0;
    push_ent        = '0;
    state_next      = state;
    bit_length_next = bit_length;
    unique case (state)
      F_PASS: begin
        if (take) begin
          push = 1'b1;
          if (!msg_word.end_of_message) begin
            push_ent.data   = msg_word.data_word;
            bit_length_next = bit_length + 64'd32;
          end else begin
            push_ent.data   = pad_word(msg_word.data_word, nbytes);
            bit_length_next = bit_length + 64'({nbytes, 3'b000});
            state_next      = (nbytes == FULL_BYTES) ? F_PAD80 : F_PAD;
          end
        end
      end
      F_PAD80: begin
        if (!full) begin
          push          = 1'b1;
          push_ent.data = PAD_WORD;
          state_next    = F_PAD;
        end
      end
      F_PAD: begin
        if (!full) begin
          push = 1'b1;
          if (fill == LEN_SLOT) begin
            push_ent.data = bit_length[63:32];
            state_next    = F_LENLO;
          end
        end
      end
      F_LENLO: begin
        if (!full) begin
          push            = 1'b1;
          push_ent.data   = bit_length[31:0];
          push_ent.last   = 1'b1;
          bit_length_next = '0;
          state_next      = F_PASS;
        end
      end
      default: state_next = F_PASS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_PASS;
      bit_length <= '0;
      fill       <= '0;
    end else begin
      state      <= state_next;
      bit_length <= bit_length_next;
      if (push) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### design/sha1md_core.sv
// Compression core: gathers 16-word blocks and runs the 80 SHA-1 rounds.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  sha1md_pkg::qent_t  pop_ent,
  output logic               pop,
  output logic               load,
  output sha1md_pkg::chain_t load_value,
  input  logic               out_busy
);
  import sha1md_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } cstate_t;

  cstate_t          state;
  logic [15:0][31:0] stage;
  logic [15:0][31:0] sched;
  logic [4:0]       stage_cnt;
  logic             stage_last;
  logic             blk_last;
  chain_t           chain;
  chain_t           sum;
  logic [31:0]      a, b, c, d, e;
  logic [6:0]       round;
  logic [31:0]      f;
  logic [31:0]      k;
  logic [31:0]      tmp;
  logic [31:0]      w_mix;
  logic             start;

  assign pop   = pop_valid && (stage_cnt != STAGE_FULL);
  assign start = (state == C_IDLE) && (stage_cnt == STAGE_FULL);

  always_comb begin
    priority if (round < ROUND_K1) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < ROUND_K2) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < ROUND_K3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp   = {a[26:0], a[31:27]} + f + e + sched[0] + k;
  assign w_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign sum   = {chain[4] + e, chain[3] + d, chain[2] + c, chain[1] + b, chain[0] + a};

  assign load       = (state == C_ADD) && blk_last && !out_busy;
  assign load_value = sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      stage_cnt <= '0;
      round     <= '0;
      chain     <= IV;
    end else begin
      if (start) begin
        stage_cnt <= '0;
      end else if (pop) begin
        stage_cnt <= stage_cnt + 1'b1;
      end
      unique case (state)
        C_IDLE: begin
          if (start) begin
            round <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          round <= round + 1'b1;
          if (round == LAST_ROUND) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          if (!blk_last) begin
            chain <= sum;
            state <= C_IDLE;
          end else if (!out_busy) begin
            chain <= IV;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      stage      <= {pop_ent.data, stage[15:1]};
      stage_last <= pop_ent.last;
    end
    if (start) begin
      sched    <= stage;
      a        <= chain[0];
      b        <= chain[1];
      c        <= chain[2];
      d        <= chain[3];
      e        <= chain[4];
      blk_last <= stage_last;
    end else if (state == C_ROUND) begin
      sched <= {{w_mix[30:0], w_mix[31]}, sched[15:1]};
      a     <= tmp;
      b     <= a;
      c     <= {b[1:0], b[31:2]};
      d     <= c;
      e     <= d;
    end
  end

endmodule
`default_nettype wire

### design/sha1md_out.sv
// Digest output buffer: holds the five digest words and sends them in order.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  sha1md_pkg::chain_t    load_value,
  output logic                  busy,
  output logic                  dig_valid,
  input  logic                  dig_stall,
  output sha1md_pkg::dig_word_t dig_word
);
  import sha1md_pkg::*;

  chain_t     held;
  logic [2:0] idx;
  logic       take;

  assign dig_valid            = busy;
  assign dig_word.digest_word = held[0];
  assign dig_word.word_index  = idx;
  assign dig_word.last_word   = (idx == LAST_INDEX);
  assign take                 = busy && !dig_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (idx == LAST_INDEX) begin
        busy <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_value;
    end else if (take) begin
      held <= {32'h0000_0000, held[4:1]};
    end
  end

endmodule
`default_nettype wire

### design/sha1_message_digest_top.sv
// Top level of the SHA-1 message digest block.
// The msg channel takes one 32-bit message word per handshake, first byte in
// bits 31..24. Words without end_of_message count as four bytes; the word with
// end_of_message carries valid_bytes of message and closes the message.
// The dig channel then returns five digest words, index 0 first, last_word set
// on the fifth one.
// Each 16-word block passes the compression core in order: one load step,
// 80 rounds at one round per cycle and one chaining add. The next block is
// gathered while a block runs.
// After the final word the front end stalls the input while it inserts the
// 2 to 18 padding words: the pad, zero fill and 64-bit length.
// The last block's chaining add hands the digest to a free output buffer.
// A stall on the dig channel holds the current word; the core keeps working
// until it needs the digest buffer for the next message.
// Reset clears the length and the block fill, sets the chaining values to IV,
// and drops any words in flight.
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_digest_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  sha1md_pkg::msg_word_t msg_word,
  output logic                  dig_valid,
  input  logic                  dig_stall,
  output sha1md_pkg::dig_word_t dig_word
);
  import sha1md_pkg::*;

  logic   push;
  qent_t  push_ent;
  logic   full;
  logic   pop_valid;
  qent_t  pop_ent;
  logic   pop;
  logic   load;
  chain_t load_value;
  logic   out_busy;

  sha1md_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_word  (msg_word),
    .push      (push),
    .push_ent  (push_ent),
    .full      (full)
  );

  sha1md_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ent  (push_ent),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_ent   (pop_ent),
    .pop       (pop)
  );

  sha1md_core u_core (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ent    (pop_ent),
    .pop        (pop),
    .load       (load),
    .load_value (load_value),
    .out_busy   (out_busy)
  );

  sha1md_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_value (load_value),
    .busy       (out_busy),
    .dig_valid  (dig_valid),
    .dig_stall  (dig_stall),
    .dig_word   (dig_word)
  );

endmodule
`default_nettype wire

### design/sha1md_checker.sv
// Port checker for the SHA-1 message digest block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  msg_valid,
  input logic                  msg_stall,
  input sha1md_pkg::msg_word_t msg_word,
  input logic                  dig_valid,
  input logic                  dig_stall,
  input sha1md_pkg::dig_word_t dig_word
);
  import sha1md_pkg::*;

  a_last_matches_index: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig_word.last_word == (dig_word.word_index == LAST_INDEX)))
    else $error("last_word does not match word_index");

  a_digest_in_sequence: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_stall && !dig_word.last_word) |=>
      (dig_valid && (dig_word.word_index == 3'($past(dig_word.word_index) + 3'd1))))
    else $error("digest words not sent back to back in order");

  a_pad_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && !msg_stall && msg_word.end_of_message) |=> msg_stall)
    else $error("input not stalled while padding is inserted");

  a_dig_hold: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_stall) |=> (dig_valid && $stable(dig_word)))
    else $error("stalled digest word changed");

endmodule

bind sha1_message_digest_top sha1md_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg_valid),
  .msg_stall (msg_stall),
  .msg_word  (msg_word),
  .dig_valid (dig_valid),
  .dig_stall (dig_stall),
  .dig_word  (dig_word)
);
`default_nettype wire
